[sv/retransmit_timer_table_top_assert.svh]
// ----------------------------------------------------------------------------
// Retransmit timer table assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef RETRANSMIT_TIMER_TABLE_TOP_ASSERT_SVH
`define RETRANSMIT_TIMER_TABLE_TOP_ASSERT_SVH

// plain invariant
`define RTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// same-cycle implication
`define RTT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[sv/rtt_pkg.sv]
// ----------------------------------------------------------------------------
// Retransmit timer table package
// Sizes, codes and the structs shared by controller, datapath and top.
// ----------------------------------------------------------------------------
package rtt_pkg;

  localparam int SLOTS    = 6;
  localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int CD_W     = 15;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  localparam logic [7:0]  HANDLE_BASE = 8'h80;
  localparam logic [23:0] NO_TIMER    = 24'hFFFFFF;

  // register map
  localparam logic REG_REPORT_EXPIRY = 1'b0;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_e;

  localparam logic [2:0] KIND_START   = 3'd0;
  localparam logic [2:0] KIND_CANCEL  = 3'd1;
  localparam logic [2:0] KIND_RETX    = 3'd2;
  localparam logic [2:0] KIND_EXPIRED = 3'd3;
  localparam logic [2:0] KIND_SUMMARY = 3'd4;

  localparam logic [1:0] STAT_OK         = 2'd0;
  localparam logic [1:0] STAT_NO_SLOT    = 2'd1;
  localparam logic [1:0] STAT_BAD_PARAM  = 2'd2;
  localparam logic [1:0] STAT_BAD_HANDLE = 2'd3;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CAPTURE,
    CMD_START_FAIL,
    CMD_START_OK,
    CMD_CANCEL,
    CMD_TICK_SLOT,
    CMD_TICK_RETX,
    CMD_TICK_EXPIRE,
    CMD_SUMMARY
  } cmd_e;

  typedef struct packed {
    cmd_e             op;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic cur_valid;
    logic cur_fire;
    logic cur_retry_zero;
    logic full;
    logic params_ok;
    logic out_busy;
    logic report_expiry;
  } dp_stat_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         msg_type;
    logic [6:0]         retries;
    logic signed [15:0] period;
    logic [15:0]        payload_tag;
    logic [15:0]        length;
    logic [7:0]         handle_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [1:0]  status;
    logic [7:0]  handle_out;
    logic [7:0]  out_type;
    logic [15:0] out_tag;
    logic [15:0] out_length;
    logic [23:0] min_left;
    logic [2:0]  peak_active;
    logic [1:0]  sticky_error;
    logic        last;
  } out_item_t;

endpackage

[sv/rtt_in_if.sv]
// ----------------------------------------------------------------------------
// Retransmit timer table request channel
// valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
interface rtt_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [7:0]         msg_type;
  logic [6:0]         retries;
  logic signed [15:0] period;
  logic [15:0]        payload_tag;
  logic [15:0]        length;
  logic [7:0]         handle_in;

  modport source (
    output valid, opcode, msg_type, retries, period, payload_tag, length, handle_in,
    input  ready
  );

  modport sink (
    input  valid, opcode, msg_type, retries, period, payload_tag, length, handle_in,
    output ready
  );
endinterface

[sv/rtt_out_if.sv]
// ----------------------------------------------------------------------------
// Retransmit timer table event channel
// valid/ready channel carrying one reply or event beat.
// ----------------------------------------------------------------------------
interface rtt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [1:0]  status;
  logic [7:0]  handle_out;
  logic [7:0]  out_type;
  logic [15:0] out_tag;
  logic [15:0] out_length;
  logic [23:0] min_left;
  logic [2:0]  peak_active;
  logic [1:0]  sticky_error;
  logic        last;

  modport source (
    output valid, event_kind, status, handle_out, out_type, out_tag, out_length,
           min_left, peak_active, sticky_error, last,
    input  ready
  );

  modport sink (
    input  valid, event_kind, status, handle_out, out_type, out_tag, out_length,
           min_left, peak_active, sticky_error, last,
    output ready
  );
endinterface

[sv/rtt_ctrl.sv]
// ----------------------------------------------------------------------------
// Retransmit timer table controller
// Sequences start, cancel, tick and clear; walks the slots one per cycle unless stalled.
// ----------------------------------------------------------------------------
`include "retransmit_timer_table_top_assert.svh"

module rtt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        opcode_i,
  output logic              in_ready_o,
  input  rtt_pkg::dp_stat_t stat_i,
  output rtt_pkg::cmd_t     cmd_o
);
  import rtt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_CANCEL,
    S_TICK,
    S_SUMMARY
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             advance;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    cmd_o.op   = CMD_NONE;
    cmd_o.idx  = idx_q;
    in_ready_o = (state_q == S_IDLE);
    advance    = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = CMD_CAPTURE;
          idx_d    = '0;
          unique case (op_e'(opcode_i))
            OP_START:  state_d = S_START;
            OP_CANCEL: state_d = S_CANCEL;
            OP_TICK:   state_d = S_TICK;
            OP_CLEAR:  state_d = S_IDLE;
          endcase
        end
      end
      S_START: begin
        priority if (stat_i.full || !stat_i.params_ok ||
                     (stat_i.cur_valid && idx_q == LAST_IDX)) begin
          if (!stat_i.out_busy) begin
            cmd_o.op = CMD_START_FAIL;
            state_d  = S_IDLE;
          end
        end else if (!stat_i.cur_valid) begin
          if (!stat_i.out_busy) begin
            cmd_o.op = CMD_START_OK;
            state_d  = S_IDLE;
          end
        end else begin
          idx_d = IDX_W'(idx_q + 1'b1);
        end
      end
      S_CANCEL: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = CMD_CANCEL;
          state_d  = S_IDLE;
        end
      end
      S_TICK: begin
        priority if (!stat_i.cur_valid) begin
          advance = 1'b1;
        end else if (!stat_i.cur_fire) begin
          cmd_o.op = CMD_TICK_SLOT;
          advance  = 1'b1;
        end else if (!stat_i.cur_retry_zero) begin
          if (!stat_i.out_busy) begin
            cmd_o.op = CMD_TICK_RETX;
            advance  = 1'b1;
          end
        end else begin
          // silent expiry needs no room downstream
          if (!(stat_i.report_expiry && stat_i.out_busy)) begin
            cmd_o.op = CMD_TICK_EXPIRE;
            advance  = 1'b1;
          end
        end
        if (advance) begin
          if (idx_q == LAST_IDX) begin
            state_d = S_SUMMARY;
          end else begin
            idx_d = IDX_W'(idx_q + 1'b1);
          end
        end
      end
      S_SUMMARY: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = CMD_SUMMARY;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  `RTT_IMPLY(a_free_slot_found, state_q == S_START && stat_i.cur_valid && idx_q == LAST_IDX, stat_i.full || !stat_i.params_ok, "start scan ran out of slots below full")
  `RTT_IMPLY(a_tick_idx_in_range, state_q == S_TICK, idx_q <= LAST_IDX, "slot index beyond table")

endmodule

[sv/rtt_dp.sv]
// ----------------------------------------------------------------------------
// Retransmit timer table datapath
// Slot storage, counters, sticky error, min tracking and the result register.
// ----------------------------------------------------------------------------
`include "retransmit_timer_table_top_assert.svh"

module rtt_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rtt_pkg::cmd_t     cmd_i,
  input  rtt_pkg::in_item_t item_i,
  input  logic              report_expiry_i,
  output rtt_pkg::dp_stat_t stat_o,
  rtt_out_if.source         out_o
);
  import rtt_pkg::*;

  in_item_t         item_q;

  logic [SLOTS-1:0] valid_q, valid_d;
  logic [7:0]       type_q [SLOTS];
  logic [6:0]       retr_q [SLOTS];
  logic [CD_W-1:0]  cd_q   [SLOTS];
  logic [CD_W-1:0]  rel_q  [SLOTS];
  logic [15:0]      tag_q  [SLOTS];
  logic [15:0]      len_q  [SLOTS];

  logic [CNT_W-1:0] active_q, active_d;
  logic [CNT_W-1:0] peak_q, peak_d;
  logic [1:0]       err_q, err_d;
  logic [23:0]      min_q, min_d;

  logic             out_valid_q, out_valid_d;
  out_item_t        res_q, res_d;
  logic             load;

  logic [CD_W-1:0]  cd_dec;
  logic [7:0]       cancel_off;
  logic             cancel_ok;
  logic [IDX_W-1:0] cancel_idx;
  logic             params_ok;
  logic             full;
  logic             busy;
  logic [7:0]       cur_handle;

  assign cd_dec     = (cd_q[cmd_i.idx] != '0) ? CD_W'(cd_q[cmd_i.idx] - 1'b1) : '0;
  assign params_ok  = !item_q.period[15] && (item_q.period != 16'sd0) &&
                      (item_q.payload_tag != 16'd0) && (item_q.length != 16'd0);
  assign full       = (active_q >= CNT_W'(SLOTS));
  assign busy       = out_valid_q && !out_o.ready;
  assign cancel_off = 8'(item_q.handle_in - HANDLE_BASE);
  assign cancel_ok  = (item_q.handle_in >= HANDLE_BASE) && (cancel_off < 8'(SLOTS));
  assign cancel_idx = cancel_off[IDX_W-1:0];
  assign cur_handle = 8'(HANDLE_BASE + 8'(cmd_i.idx));

  assign stat_o.cur_valid      = valid_q[cmd_i.idx];
  assign stat_o.cur_fire       = (cd_dec == '0);
  assign stat_o.cur_retry_zero = (retr_q[cmd_i.idx] == 7'd0);
  assign stat_o.full           = full;
  assign stat_o.params_ok      = params_ok;
  assign stat_o.out_busy       = busy;
  assign stat_o.report_expiry  = report_expiry_i;

  always_comb begin
    valid_d  = valid_q;
    active_d = active_q;
    peak_d   = peak_q;
    err_d    = err_q;
    min_d    = min_q;
    load     = 1'b0;
    res_d    = '0;
    unique case (cmd_i.op)
      CMD_NONE: begin
      end
      CMD_CAPTURE: begin
        if (item_i.opcode == OP_CLEAR) begin
          err_d = STAT_OK;
        end
        if (item_i.opcode == OP_TICK) begin
          min_d = NO_TIMER;
          if (active_q != '0 && active_q > peak_q) begin
            peak_d = active_q;
          end
        end
      end
      CMD_START_FAIL: begin
        load             = 1'b1;
        res_d.event_kind = KIND_START;
        res_d.status     = (!full && !params_ok) ? STAT_BAD_PARAM : STAT_NO_SLOT;
        res_d.last       = 1'b1;
        err_d            = res_d.status;
      end
      CMD_START_OK: begin
        load                 = 1'b1;
        valid_d[cmd_i.idx]   = 1'b1;
        active_d             = CNT_W'(active_q + 1'b1);
        res_d.event_kind     = KIND_START;
        res_d.status         = STAT_OK;
        res_d.handle_out     = cur_handle;
        res_d.last           = 1'b1;
      end
      CMD_CANCEL: begin
        load             = 1'b1;
        res_d.event_kind = KIND_CANCEL;
        res_d.handle_out = item_q.handle_in;
        res_d.last       = 1'b1;
        if (cancel_ok) begin
          res_d.status = STAT_OK;
          if (valid_q[cancel_idx]) begin
            valid_d[cancel_idx] = 1'b0;
            active_d            = CNT_W'(active_q - 1'b1);
          end
        end else begin
          res_d.status = STAT_BAD_HANDLE;
          err_d        = STAT_BAD_HANDLE;
        end
      end
      CMD_TICK_SLOT: begin
        if (24'(cd_dec) < min_q) begin
          min_d = 24'(cd_dec);
        end
      end
      CMD_TICK_RETX: begin
        min_d            = '0;
        load             = 1'b1;
        res_d.event_kind = KIND_RETX;
        res_d.handle_out = cur_handle;
        res_d.out_type   = type_q[cmd_i.idx];
        res_d.out_tag    = tag_q[cmd_i.idx];
        res_d.out_length = len_q[cmd_i.idx];
      end
      CMD_TICK_EXPIRE: begin
        min_d              = '0;
        valid_d[cmd_i.idx] = 1'b0;
        active_d           = CNT_W'(active_q - 1'b1);
        load               = report_expiry_i;
        res_d.event_kind   = KIND_EXPIRED;
        res_d.handle_out   = cur_handle;
        res_d.out_type     = type_q[cmd_i.idx];
        res_d.out_tag      = tag_q[cmd_i.idx];
        res_d.out_length   = len_q[cmd_i.idx];
      end
      CMD_SUMMARY: begin
        load              = 1'b1;
        res_d.event_kind  = KIND_SUMMARY;
        res_d.min_left    = min_q;
        res_d.peak_active = 3'(peak_q);
        res_d.last        = 1'b1;
      end
      default: begin
      end
    endcase
    res_d.sticky_error = err_d;
    out_valid_d        = load || (out_valid_q && !out_o.ready);
  end

  // slot payload, written only where the command names a slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == CMD_START_OK) begin
      type_q[cmd_i.idx] <= item_q.msg_type;
      retr_q[cmd_i.idx] <= item_q.retries;
      cd_q[cmd_i.idx]   <= item_q.period[CD_W-1:0];
      rel_q[cmd_i.idx]  <= item_q.period[CD_W-1:0];
      tag_q[cmd_i.idx]  <= item_q.payload_tag;
      len_q[cmd_i.idx]  <= item_q.length;
    end else if (cmd_i.op == CMD_TICK_RETX) begin
      retr_q[cmd_i.idx] <= 7'(retr_q[cmd_i.idx] - 1'b1);
      cd_q[cmd_i.idx]   <= rel_q[cmd_i.idx];
    end else if (cmd_i.op == CMD_TICK_SLOT) begin
      cd_q[cmd_i.idx]   <= cd_dec;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == CMD_CAPTURE) begin
      item_q <= item_i;
    end
    if (load) begin
      res_q <= res_d;
    end
    min_q <= min_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      active_q    <= '0;
      peak_q      <= '0;
      err_q       <= STAT_OK;
      out_valid_q <= 1'b0;
    end else begin
      valid_q     <= valid_d;
      active_q    <= active_d;
      peak_q      <= peak_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.event_kind   = res_q.event_kind;
  assign out_o.status       = res_q.status;
  assign out_o.handle_out   = res_q.handle_out;
  assign out_o.out_type     = res_q.out_type;
  assign out_o.out_tag      = res_q.out_tag;
  assign out_o.out_length   = res_q.out_length;
  assign out_o.min_left     = res_q.min_left;
  assign out_o.peak_active  = res_q.peak_active;
  assign out_o.sticky_error = res_q.sticky_error;
  assign out_o.last         = res_q.last;

  `RTT_ASSERT(a_active_matches, active_q == CNT_W'($countones(valid_q)), "active count out of step with slot valid bits")
  `RTT_IMPLY(a_no_load_when_busy, load, !busy, "result loaded over a waiting beat")
  `RTT_IMPLY(a_expire_has_slot, cmd_i.op == CMD_TICK_EXPIRE, valid_q[cmd_i.idx] && active_q != '0, "expiry on a free slot")

endmodule

[sv/retransmit_timer_table_top.sv]
// ----------------------------------------------------------------------------
// Retransmit timer table, top level
// Throughput: one beat at a time; the tick walks one slot a cycle unless stalled.
// Reset: all slots free, counts and sticky error cleared, expiry reports off.
// ----------------------------------------------------------------------------
module retransmit_timer_table_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration, APB style
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // command and event channels
  rtt_in_if.sink      in_chan_i,
  rtt_out_if.source   out_chan_o
);
  import rtt_pkg::*;

  // Structure
  //   rtt_ctrl : takes a command beat only while idle, then steps the
  //              datapath one slot per cycle unless stalled (start scan or tick walk).
  //   rtt_dp   : holds the slot table, active/peak counters, sticky
  //              error, tick minimum and a single result register.
  // A result waits in the register while the controller moves on; the
  // controller only stalls when it has a new beat to load and the held
  // one has not been taken.

  logic     report_expiry_q;
  logic     cfg_wr;
  cmd_t     cmd;
  dp_stat_t stat;
  in_item_t item;
  logic     in_ready;

  // register 0 at byte address 0; bit 2 selects beyond the map
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_REPORT_EXPIRY);
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_REPORT_EXPIRY) ? {31'd0, report_expiry_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      report_expiry_q <= 1'b0;
    end else if (cfg_wr) begin
      report_expiry_q <= pwdata[0];
    end
  end

  assign item.opcode      = in_chan_i.opcode;
  assign item.msg_type    = in_chan_i.msg_type;
  assign item.retries     = in_chan_i.retries;
  assign item.period      = in_chan_i.period;
  assign item.payload_tag = in_chan_i.payload_tag;
  assign item.length      = in_chan_i.length;
  assign item.handle_in   = in_chan_i.handle_in;

  assign in_chan_i.ready = in_ready;

  rtt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan_i.valid),
    .opcode_i   (in_chan_i.opcode),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rtt_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .item_i          (item),
    .report_expiry_i (report_expiry_q),
    .stat_o          (stat),
    .out_o           (out_chan_o)
  );

endmodule
